@@ sv/tooth_wheel_speed_meter_unit_assert.svh @@
// assertion macros for the checker file
// both sample on clk and stay quiet while rst_n is low
`ifndef TOOTH_WHEEL_SPEED_METER_UNIT_ASSERT_SVH
`define TOOTH_WHEEL_SPEED_METER_UNIT_ASSERT_SVH

// same-cycle implication
`define TWSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twsm assertion failed");

// next-cycle implication
`define TWSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twsm assertion failed");

`endif

@@ sv/twsm_pkg.sv @@
package twsm_pkg;

  // default sizes
  localparam int TICK_WIDTH_DEF    = 32;
  localparam int RPM_FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int TEETH_W   = 8;
  localparam int TIMEOUT_W = 20;
  localparam int RPM_W     = 32;
  localparam int IN_DATA_W = 8;

  // 60e6 rpm-microseconds fits in 26 bits
  localparam longint unsigned RPM_BASE   = 64'd60000000;
  localparam int              NUM_BASE_W = 26;

  // register reset values
  localparam logic [TEETH_W-1:0]   TEETH_RST   = 8'd49;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd10000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TEETH   = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

  // edge detector phase
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_LOW   = 2'd1,
    PH_ARMED = 2'd2
  } phase_t;

  // divider sequencer
  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_MUL  = 2'd1,
    DV_DIV  = 2'd2
  } div_state_t;

  // events from the tick tracker
  typedef struct packed {
    logic close;
    logic stop;
  } tick_ev_t;

endpackage

@@ sv/twsm_tick.sv @@
module twsm_tick #(
  parameter int TICK_WIDTH = twsm_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           pin_level,
  input  logic [twsm_pkg::TIMEOUT_W-1:0] timeout_us,
  output twsm_pkg::tick_ev_t             ev,
  output logic [TICK_WIDTH-1:0]          period
);
  import twsm_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

  phase_t                phase_r, phase_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [TICK_WIDTH-1:0] start_r, start_nxt;
  logic [TICK_WIDTH-1:0] last_r, last_nxt;
  logic                  stop_rep_r, stop_rep_nxt;
  logic [TICK_WIDTH-1:0] idle_ticks;
  logic                  close;
  logic                  expired;

  // phase update and period close for the current tick
  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    close     = 1'b0;
    case (phase_r)
      PH_LOW: begin
        if (pin_level) begin
          phase_nxt = PH_ARMED;
        end
      end
      PH_ARMED: begin
        if (!pin_level) begin
          close     = 1'b1;
          phase_nxt = PH_LOW;
          start_nxt = tick_r;
        end
      end
      default: begin
        if (!pin_level) begin
          phase_nxt = PH_LOW;
          start_nxt = tick_r;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
    endcase
  end

  // timeout since last close, modulo tick width
  assign idle_ticks = tick_r - last_r;
  assign expired    = CMP_W'(idle_ticks) > CMP_W'(timeout_us);

  assign period   = tick_r - start_r;
  assign ev.close = close;
  assign ev.stop  = !close && !stop_rep_r && expired;

  always_comb begin
    tick_nxt     = tick_r + TICK_WIDTH'(1);
    last_nxt     = close ? tick_r : last_r;
    stop_rep_nxt = close ? 1'b0 : (stop_rep_r | ev.stop);
  end

  // state advances once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      tick_r     <= '0;
      start_r    <= '0;
      last_r     <= '0;
      stop_rep_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      start_r    <= start_nxt;
      last_r     <= last_nxt;
      stop_rep_r <= stop_rep_nxt;
    end
  end

endmodule

@@ sv/twsm_div.sv @@
module twsm_div #(
  parameter int TICK_WIDTH    = twsm_pkg::TICK_WIDTH_DEF,
  parameter int RPM_FRAC_BITS = twsm_pkg::RPM_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [twsm_pkg::TEETH_W-1:0] teeth,
  input  logic [TICK_WIDTH-1:0]        period,
  output logic                         busy,
  output logic                         done,
  output logic [twsm_pkg::RPM_W-1:0]   rpm
);
  import twsm_pkg::*;

  localparam int NUM_W = NUM_BASE_W + RPM_FRAC_BITS;
  localparam int DEN_W = TEETH_W + TICK_WIDTH;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int WIDE_W = NUM_W + RPM_W;
  localparam logic [NUM_W-1:0] NUM = NUM_W'(RPM_BASE) << RPM_FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  div_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TEETH_W-1:0]   teeth_r, teeth_nxt;
  logic [TICK_WIDTH-1:0] period_r, period_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W:0]       rem_shift;
  logic [DEN_W:0]       rem_diff;
  logic                 q_bit;
  logic [WIDE_W-1:0]    quo_wide;
  logic                 sat;

  // one restoring step: shift in next numerator bit, trial subtract
  assign rem_shift = {rem_r, quo_r[NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign q_bit     = !rem_diff[DEN_W];

  // saturate on a zero divisor or a quotient beyond the field
  assign quo_wide = {{RPM_W{1'b0}}, quo_nxt};
  assign sat      = (den_r == '0) || (|quo_wide[WIDE_W-1:RPM_W]);
  assign rpm      = sat ? {RPM_W{1'b1}} : quo_wide[RPM_W-1:0];
  assign busy     = (state_r != DV_IDLE);

  // sequencer: latch operands, multiply once, then one quotient bit a cycle
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    teeth_nxt  = teeth_r;
    period_nxt = period_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    done       = 1'b0;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          teeth_nxt  = teeth;
          period_nxt = period;
          state_nxt  = DV_MUL;
        end
      end
      DV_MUL: begin
        den_nxt   = DEN_W'(teeth_r) * DEN_W'(period_r);
        rem_nxt   = '0;
        quo_nxt   = NUM;
        cnt_nxt   = CNT_LAST;
        state_nxt = DV_DIV;
      end
      DV_DIV: begin
        rem_nxt = q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], q_bit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          done      = 1'b1;
          state_nxt = DV_IDLE;
        end
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    teeth_r  <= teeth_nxt;
    period_r <= period_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
  end

endmodule

@@ sv/tooth_wheel_speed_meter_unit.sv @@
// Tooth wheel speed meter.
// Input stream: one word per microsecond tick, in_tdata[0] is the sensed pin
// level. A low after a high closes one tooth period; the period in ticks is
// measured between closes and the speed is reported as
// rpm = 60e6 / (teeth * period), unsigned with RPM_FRAC_BITS fraction bits,
// saturated to all ones. If no period closes for more than timeout_us ticks,
// one stopped word (out_tuser[0] = 1, rpm 0) is sent until the next close.
// Config channel: cfg_index 0 writes teeth_per_rev, 1 writes timeout_us;
// cfg_ready is always high and writes apply on the next cycle.
// A tick without a result does not hold off the next tick. A close latches
// its operands and takes one multiply step, then the restoring divider
// gives one quotient bit per cycle; in_tready stays low meanwhile.
// Stopped words appear in the cycle after the tick is accepted.
// A finished word sits in the output register; a new tick is taken while
// out_tready drains it, and in_tready drops while a word is stalled.
// Reset clears phase, tick counter and reports; registers return to 49 teeth
// and a 10000 tick timeout.
module tooth_wheel_speed_meter_unit #(
  parameter int TICK_WIDTH    = twsm_pkg::TICK_WIDTH_DEF,
  parameter int RPM_FRAC_BITS = twsm_pkg::RPM_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [0] pin_level, [7:1] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [twsm_pkg::IN_DATA_W-1:0] in_tdata,
  // out_tdata: [31:0] rpm_q8
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [twsm_pkg::RPM_W-1:0]     out_tdata,
  // out_tuser: [0] stopped
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  twsm_pkg::reg_idx_t             cfg_index,
  input  logic [twsm_pkg::TIMEOUT_W-1:0] cfg_data
);
  import twsm_pkg::*;

  logic [TEETH_W-1:0]    teeth_r;
  logic [TIMEOUT_W-1:0]  timeout_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0]      out_rpm_r, out_rpm_nxt;
  logic                  out_stop_r, out_stop_nxt;
  logic                  accept;
  tick_ev_t              ev;
  logic [TICK_WIDTH-1:0] period;
  logic                  div_busy;
  logic                  div_done;
  logic [RPM_W-1:0]      div_rpm;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      teeth_r   <= TEETH_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEETH:   teeth_r   <= cfg_data[TEETH_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // take a tick when the divider is free and the output can drain
  assign in_tready = !div_busy && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  twsm_tick #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_tick (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pin_level  (in_tdata[0]),
    .timeout_us (timeout_r),
    .ev         (ev),
    .period     (period)
  );

  twsm_div #(
    .TICK_WIDTH    (TICK_WIDTH),
    .RPM_FRAC_BITS (RPM_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && ev.close),
    .teeth  (teeth_r),
    .period (period),
    .busy   (div_busy),
    .done   (div_done),
    .rpm    (div_rpm)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_rpm_nxt   = out_rpm_r;
    out_stop_nxt  = out_stop_r;
    if (div_done) begin
      out_valid_nxt = 1'b1;
      out_rpm_nxt   = div_rpm;
      out_stop_nxt  = 1'b0;
    end else if (accept && ev.stop) begin
      out_valid_nxt = 1'b1;
      out_rpm_nxt   = '0;
      out_stop_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rpm_r  <= out_rpm_nxt;
    out_stop_r <= out_stop_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_rpm_r;
  assign out_tuser[0] = out_stop_r;

endmodule

@@ sv/twsm_chk.sv @@
`include "tooth_wheel_speed_meter_unit_assert.svh"

module twsm_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [twsm_pkg::RPM_W-1:0] out_tdata,
  input logic [0:0]                 out_tuser,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  // a stalled result word holds
  `TWSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a stopped report always carries zero speed
  `TWSM_ASSERT_IMPL(a_stop_zero, out_tvalid && out_tuser[0], out_tdata == '0)

  // no tick is taken while a result word is stuck
  `TWSM_ASSERT_IMPL(a_no_take_on_stall, in_tready, !out_tvalid || out_tready)

  // register writes are never refused
  `TWSM_ASSERT_IMPL(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind tooth_wheel_speed_meter_unit twsm_chk u_twsm_chk (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import twsm_pkg::*;

  localparam int unsigned RPM_FRAC = RPM_FRAC_BITS_DEF;
  localparam longint unsigned RPM_NUMERATOR = 64'd60000000 << RPM_FRAC;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS = 80;
  localparam int LIMIT_CYCLES = 600000;

  // one result word as the checker sees it
  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             stopped;
  } speed_word_t;

  // directed table row: a tick or a register write
  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic [TIMEOUT_W-1:0] val;
    bit                 pin;
    bit                 typed;
    bit                 has_res;
    logic [RPM_W-1:0]   rpm;
    bit                 stp;
  } dir_row_t;

  localparam int DIR_ROWS = 30;
  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset settings: wait for a low, then closes of three and two ticks
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b1, 32'd104489795, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b1, 32'd156734693, 1'b0},
    // zero teeth saturates, zero timeout stops on the next tick
    '{ROW_CFG, REG_TEETH, 20'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, REG_TIMEOUT, 20'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b1, 1'b1, 32'd0, 1'b1},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b1, 32'd0, 1'b1},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
    // one tooth, widest timeout: short periods overflow the field
    '{ROW_CFG, REG_TEETH, 20'd1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, REG_TIMEOUT, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // most teeth, then a stop after a short timeout
    '{ROW_CFG, REG_TEETH, 20'd255, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, REG_TIMEOUT, 20'd5, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_TICK, REG_TEETH, 20'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0}
  };

  // block ports
  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [RPM_W-1:0]     out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  reg_idx_t             cfg_index = REG_TEETH;
  logic [TIMEOUT_W-1:0] cfg_data = '0;

  tooth_wheel_speed_meter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state, mirrors the block after reset
  phase_t               edge_ph = PH_WAIT;
  logic [31:0]          tick_now = '0;
  logic [31:0]          tooth_start = '0;
  logic [31:0]          last_close = '0;
  bit                   stop_done = 1'b0;
  logic [TEETH_W-1:0]   teeth = TEETH_RST;
  logic [TIMEOUT_W-1:0] stop_after = TIMEOUT_RST;

  speed_word_t rpm_words_due[$];

  // run control and bookkeeping
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int ticks_sent = 0;
  int speed_words = 0;
  int stop_words = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // speed for one closed period at the current tooth count
  function automatic logic [RPM_W-1:0] rpm_from_period(logic [31:0] period);
    longint unsigned q;
    if (period == 0 || teeth == 0) return '1;
    if (64'(period) > RPM_NUMERATOR) return '0;
    q = RPM_NUMERATOR / (64'(teeth) * 64'(period));
    return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
  endfunction

  // one microsecond tick through the edge detector and timeout watch
  function automatic void advance_tick(input bit pin, output bit got,
                                       output speed_word_t word);
    logic [31:0] now;
    now = tick_now;
    got = 1'b0;
    word = '0;
    case (edge_ph)
      PH_LOW: begin
        if (pin) edge_ph = PH_ARMED;
      end
      PH_ARMED: begin
        if (!pin) begin
          word.rpm = rpm_from_period(now - tooth_start);
          word.stopped = 1'b0;
          got = 1'b1;
          tooth_start = now;
          last_close = now;
          stop_done = 1'b0;
          edge_ph = PH_LOW;
        end
      end
      default: begin
        if (!pin) begin
          edge_ph = PH_LOW;
          tooth_start = now;
        end else begin
          edge_ph = PH_WAIT;
        end
      end
    endcase
    if (!got && !stop_done && (now - last_close) > 32'(stop_after)) begin
      stop_done = 1'b1;
      word = '{rpm: '0, stopped: 1'b1};
      got = 1'b1;
    end
    tick_now = now + 1;
  endfunction

  // offer one tick word, with optional idle cycles in front
  task automatic send_tick(input bit pin, input bit typed = 1'b0,
                           input bit typed_has = 1'b0,
                           input speed_word_t typed_word = '0);
    bit got;
    speed_word_t word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W-1){1'b0}}, pin};
    do @(posedge clk); while (!in_tready);
    advance_tick(pin, got, word);
    if (typed) begin
      got = typed_has;
      word = typed_word;
    end
    if (got) rpm_words_due.push_back(word);
    ticks_sent++;
  endtask

  // stop offering and wait for every due word
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rpm_words_due.size() != 0);
  endtask

  // register write once the block has gone quiet
  task automatic set_reg(input reg_idx_t idx, input logic [TIMEOUT_W-1:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEETH: teeth = val[TEETH_W-1:0];
      default:   stop_after = val;
    endcase
    reg_writes++;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    speed_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser[0]) stop_words++;
      else speed_words++;
      if (rpm_words_due.size() == 0) begin
        $error("unexpected word: rpm_q8 %0d stopped %0d", out_tdata, out_tuser[0]);
        errors++;
      end else begin
        want = rpm_words_due.pop_front();
        if (out_tdata !== want.rpm) begin
          $error("rpm_q8 mismatch: expected %0d, got %0d", want.rpm, out_tdata);
          errors++;
        end
        if (out_tuser[0] !== want.stopped) begin
          $error("stopped mismatch: expected %0d, got %0d", want.stopped, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[tooth_wheel_speed_meter_unit] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int seg;
    int n;
    int lo;
    int hi;
    int k;
    int maxrun;
    bit paused;
    logic [TEETH_W-1:0] teeth_w;
    logic [TIMEOUT_W-1:0] tmo_w;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].has_res,
                  '{rpm: dir_rows[i].rpm, stopped: dir_rows[i].stp});
      end
    end

    // random waveforms, two settings per idling mode
    for (seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      case (seg)
        0: begin teeth_w = 8'd255; tmo_w = 20'd0; end
        1: begin teeth_w = 8'd1; tmo_w = 20'hFFFFF; end
        2: begin teeth_w = 8'd0; tmo_w = 20'd30; end
        3: begin teeth_w = TEETH_RST; tmo_w = 20'd1; end
        default: begin
          teeth_w = TEETH_W'($urandom_range(255));
          tmo_w = TIMEOUT_W'($urandom_range(1, 120));
        end
      endcase
      set_reg(REG_TEETH, TIMEOUT_W'(teeth_w));
      set_reg(REG_TIMEOUT, tmo_w);

      n = 0;
      paused = 1'b0;
      while (n < SEG_ITEMS) begin
        // long receiver hold-off while ticks keep coming
        if (seg == 0 && n >= 40 && hold_req == hold_ack && hold_left == 0 && !paused)
          hold_req = ~hold_req;
        // sender waits out every due word once per segment
        if (n >= 70 && !paused) begin
          drain();
          paused = 1'b1;
        end
        maxrun = ($urandom_range(9) == 0) ? 160 : 12;
        if ($urandom_range(99) < 85) begin
          // one tooth: low run then high run
          lo = $urandom_range(1, maxrun);
          hi = $urandom_range(1, maxrun);
          repeat (lo) send_tick(1'b0);
          repeat (hi) send_tick(1'b1);
          n += lo + hi;
        end else begin
          // noise
          k = $urandom_range(1, 8);
          repeat (k) send_tick(1'($urandom_range(1)));
          n += k;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d ticks and %0d register writes across four idling modes",
             ticks_sent, reg_writes);
    $display("saw %0d speed words and %0d stopped words", speed_words, stop_words);
    if (errors == 0) begin
      $display("[tooth_wheel_speed_meter_unit] OK");
    end else begin
      $display("[tooth_wheel_speed_meter_unit] ERROR");
    end
    $finish;
  end

endmodule
